[rtl/previous_greater_element_finder_macros.svh]
// ----------------------------------------------------------------------------
// previous greater element finder: assertion macros
// Shared concurrent assertion forms, clocked on clk and masked during rst.
// ----------------------------------------------------------------------------
`ifndef PREVIOUS_GREATER_ELEMENT_FINDER_MACROS_SVH
`define PREVIOUS_GREATER_ELEMENT_FINDER_MACROS_SVH

// same-cycle implication
`define PGEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pgef_pkg.sv]
// ----------------------------------------------------------------------------
// pgef_pkg
// Widths, record types and stack sizing for the previous greater element finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgef_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = ADDR_W + 1;

  localparam int COUNT_W = 20;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;

  typedef struct packed {
    logic               first_of_set;
    logic [COUNT_W-1:0] count;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [DAY_W-1:0]   found_day;
    logic [MONTH_W-1:0] found_month;
    logic [YEAR_W-1:0]  found_year;
    logic               overflow;
  } out_item_t;

  // one stack slot
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/pgef_in_if.sv]
// ----------------------------------------------------------------------------
// pgef_in_if
// Valid/ready channel carrying one input record per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pgef_in_if import pgef_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[rtl/pgef_out_if.sv]
// ----------------------------------------------------------------------------
// pgef_out_if
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pgef_out_if import pgef_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[rtl/pgef_ram.sv]
// ----------------------------------------------------------------------------
// pgef_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/previous_greater_element_finder.sv]
// ----------------------------------------------------------------------------
// previous_greater_element_finder
// Monotonic-stack search for the latest earlier record with a greater count.
// ----------------------------------------------------------------------------
// For each record accepted on the records channel the block returns one
// result on the results channel: the date of the most recent earlier record
// of the same set whose count is strictly greater, or found = 0 with zero
// date fields. The set's records live in an on-chip stack RAM
// (STACK_DEPTH entries) with strictly decreasing counts; first_of_set empties
// it before the record is processed. When the stack is still full after the
// pops the answer is reported but the record is dropped and overflow is set.
// One record is in work at a time, and every compare needs one registered
// read of the single stack RAM read port. ready comes back in the same cycle
// the result is presented. Each record is pushed at most once (a dropped
// record is not pushed) and popped at most once. A result not yet taken
// holds up only the end of the next record, not its search. The stack RAM
// needs no clearing after reset: only entries below the depth count are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "previous_greater_element_finder_macros.svh"

module previous_greater_element_finder import pgef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pgef_in_if.sink     records,
  pgef_out_if.source  results
);

  typedef enum logic [1:0] {
    ST_IDLE,  // waiting for a record
    ST_READ,  // top-of-stack data present, compare and pop
    ST_DONE   // push and hand over the result
  } state_t;

  state_t           state;
  in_item_t         cur;        // record in work
  logic [DEPTH_W-1:0] depth;    // live stack entries
  out_item_t        answer;     // answer found so far (overflow filled at the end)

  logic               accept;
  logic [DEPTH_W-1:0] depth_start;
  logic [DEPTH_W-1:0] start_top;
  logic [DEPTH_W-1:0] next_top;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_word;
  entry_t             top;
  logic               pop;
  logic               out_free;
  logic               full;
  logic               load;
  logic               push;
  entry_t             wr_entry;

  // ---------------------------------------------------------------------------
  // control decode
  // ---------------------------------------------------------------------------
  always_comb begin
    records.ready = (state == ST_IDLE);
    accept        = records.valid && records.ready;
    // a new set starts from an empty stack
    depth_start   = records.item.first_of_set ? '0 : depth;
    start_top     = depth_start - DEPTH_W'(1);
    next_top      = depth - DEPTH_W'(2);
    // address of the entry compared in the next cycle
    case (state)
      ST_IDLE: rd_addr = start_top[ADDR_W-1:0];
      ST_READ: rd_addr = next_top[ADDR_W-1:0];
      default: rd_addr = next_top[ADDR_W-1:0];
    endcase
    top      = entry_t'(rd_word);
    // equal counts are popped too
    pop      = (top.count <= cur.count);
    out_free = !results.valid || results.ready;
    full     = (depth == DEPTH_W'(STACK_DEPTH));
    // result register loaded this cycle
    load     = (state == ST_DONE) && out_free;
    push     = load && !full;
    wr_entry = '{count: cur.count, day: cur.day, month: cur.month, year: cur.year};
  end

  // ---------------------------------------------------------------------------
  // stack storage
  // ---------------------------------------------------------------------------
  pgef_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (depth[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // ---------------------------------------------------------------------------
  // sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      depth         <= '0;
      results.valid <= 1'b0;
    end else begin
      // a new result replaces the one taken in this cycle
      if (results.valid && results.ready && !load) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur    <= records.item;
            depth  <= depth_start;
            answer <= '0;
            // empty stack: nothing to compare against
            state  <= (depth_start == '0) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          if (pop) begin
            depth <= depth - DEPTH_W'(1);
            if (depth == DEPTH_W'(1)) begin
              state <= ST_DONE;
            end
          end else begin
            answer <= '{found:       1'b1,
                        found_day:   top.day,
                        found_month: top.month,
                        found_year:  top.year,
                        overflow:    1'b0};
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait here until the result register is free
          if (out_free) begin
            results.valid <= 1'b1;
            results.item  <= '{found:       answer.found,
                               found_day:   answer.found_day,
                               found_month: answer.found_month,
                               found_year:  answer.found_year,
                               overflow:    full};
            if (!full) begin
              depth <= depth + DEPTH_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PGEF_ASSERT_NOW(a_depth_bound, 1'b1, depth <= DEPTH_W'(STACK_DEPTH), "depth past capacity")
  `PGEF_ASSERT_NOW(a_read_nonempty, state == ST_READ, depth != '0, "compare on an empty stack")
  `PGEF_ASSERT_NEXT(a_push_grows, push, depth == $past(depth) + DEPTH_W'(1), "push lost")
  `PGEF_ASSERT_NEXT(a_accept_busy, accept, !records.ready, "ready while a record is in work")

endmodule
